FILE: rtl/crc8fcr_pkg.sv
// Package for the CRC-8 framed command receiver.
// Holds the parser state type, status codes, result struct and the CRC-8 step.
// No dependencies.
package crc8fcr_pkg;

	localparam logic [7:0] CRC_POLY   = 8'h8C;
	localparam logic [7:0] HDR_FIRST  = 8'h55;
	localparam logic [7:0] HDR_SECOND = 8'hAA;
	localparam int unsigned STORE_DEPTH = 16;
	localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
	localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_LEN,
		ST_DATA,
		ST_CRC,
		ST_TAIL
	} rx_state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] w_bits;
		logic [7:0]  motion_flag;
		logic [7:0]  roller_next;
		logic [7:0]  intake_next;
		logic [7:0]  intake_open;
		logic [1:0]  status;
	} result_t;

	// reflected CRC-8 update, one byte
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	localparam logic [7:0] CRC_AFTER_HDR = crc8_update(crc8_update(8'h00, HDR_FIRST), HDR_SECOND);

endpackage

FILE: rtl/crc8fcr_parser.sv
// Frame parser: header hunt, length/payload/CRC/tail sequencing and payload store.
// Builds at most one result per word from the current state and the incoming word.
// Depends on crc8fcr_pkg.
module crc8fcr_parser #(
	parameter int unsigned MAX_PAYLOAD = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           rx_byte,
	output crc8fcr_pkg::result_t result
);
	import crc8fcr_pkg::*;

	rx_state_t  state_q, state_d;
	logic [7:0] prev_q, prev_d;
	logic [5:0] count_q, count_d;
	logic [5:0] len_q, len_d;
	logic [7:0] crc_q, crc_d;
	logic       tail_q, tail_d;
	logic [7:0] store_q [STORE_DEPTH];
	logic       store_we;
	logic [7:0] crc_next;
	logic [5:0] count_inc;
	logic       len_big;
	logic       crc_bad;

	assign crc_next  = crc8_update(crc_q, rx_byte);
	assign count_inc = count_q + 6'd1;
	assign len_big   = {24'd0, rx_byte} > MAX_PAYLOAD;
	assign crc_bad   = rx_byte != crc_q;

	// next state
	always_comb begin
		state_d  = state_q;
		prev_d   = prev_q;
		count_d  = count_q;
		len_d    = len_q;
		crc_d    = crc_q;
		tail_d   = tail_q;
		store_we = 1'b0;
		case (state_q)
			ST_HUNT: begin
				if (rx_byte == HDR_SECOND) begin
					if (prev_q == HDR_FIRST) begin
						state_d = ST_LEN;
						count_d = '0;
						tail_d  = 1'b0;
						crc_d   = CRC_AFTER_HDR;
					end
				end else begin
					prev_d = rx_byte;
				end
			end
			ST_LEN: begin
				crc_d = crc_next;
				if (len_big) begin
					state_d = ST_HUNT;
				end else begin
					len_d   = rx_byte[5:0];
					count_d = '0;
					state_d = (rx_byte[5:0] == 6'd0) ? ST_CRC : ST_DATA;
				end
			end
			ST_DATA: begin
				crc_d    = crc_next;
				store_we = (count_q < 6'(STORE_DEPTH));
				count_d  = count_inc;
				if (count_inc >= len_q) begin
					state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				if (crc_bad) begin
					state_d = ST_HUNT;
				end else begin
					state_d = ST_TAIL;
					tail_d  = 1'b0;
				end
			end
			ST_TAIL: begin
				if (!tail_q) begin
					tail_d = 1'b1;
				end else begin
					state_d = ST_HUNT;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
		// any return to hunt restarts with a clean context
		if (state_q != ST_HUNT && state_d == ST_HUNT) begin
			prev_d  = '0;
			count_d = '0;
			len_d   = '0;
			crc_d   = '0;
			tail_d  = 1'b0;
		end
	end

	// outputs
	always_comb begin
		result = '0;
		case (state_q)
			ST_LEN: begin
				if (len_big) begin
					result.valid  = 1'b1;
					result.status = STATUS_LEN_ERR;
				end
			end
			ST_CRC: begin
				if (crc_bad) begin
					result.valid  = 1'b1;
					result.status = STATUS_CRC_ERR;
				end
			end
			ST_TAIL: begin
				if (tail_q) begin
					result.valid       = 1'b1;
					result.status      = STATUS_OK;
					result.x_bits      = {store_q[3], store_q[2], store_q[1], store_q[0]};
					result.y_bits      = {store_q[7], store_q[6], store_q[5], store_q[4]};
					result.w_bits      = {store_q[11], store_q[10], store_q[9], store_q[8]};
					result.motion_flag = store_q[12];
					result.roller_next = store_q[13];
					result.intake_next = store_q[14];
					result.intake_open = store_q[15];
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			prev_q  <= '0;
			count_q <= '0;
			len_q   <= '0;
			crc_q   <= '0;
			tail_q  <= 1'b0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (step) begin
			state_q <= state_d;
			prev_q  <= prev_d;
			count_q <= count_d;
			len_q   <= len_d;
			crc_q   <= crc_d;
			tail_q  <= tail_d;
			if (store_we) begin
				store_q[count_q[STORE_AW-1:0]] <= rx_byte;
			end
		end
	end

endmodule

FILE: rtl/crc8_framed_command_receiver.sv
// Top level of the CRC-8 framed command receiver: input register, parser, result register.
// Depends on crc8fcr_pkg and crc8fcr_parser.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| x_bits y_bits w_bits motion_flag roller_next
//          |                      | intake_next intake_open status
//
// One word per cycle unless a held result stalls; a word is parsed from the input register
// when it advances, and its result, if any, is loaded into the result register at that edge.
// The parse step is a combinational CRC-8 update plus frame sequencing.
// Reset clears the parser, the payload store and both valid flags.
// A held result stalls parsing; one word still waits in the input register.
module crc8_framed_command_receiver #(
	parameter int unsigned MAX_PAYLOAD = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] x_bits,
	output logic [31:0] y_bits,
	output logic [31:0] w_bits,
	output logic [7:0]  motion_flag,
	output logic [7:0]  roller_next,
	output logic [7:0]  intake_next,
	output logic [7:0]  intake_open,
	output logic [1:0]  status
);
	import crc8fcr_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	result_t    res;
	result_t    out_q;

	assign advance  = valid_s1 && (!out_q.valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	crc8fcr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(byte_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance && res.valid) begin
			out_q <= res;
		end else if (out_ready) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid   = out_q.valid;
	assign x_bits      = out_q.x_bits;
	assign y_bits      = out_q.y_bits;
	assign w_bits      = out_q.w_bits;
	assign motion_flag = out_q.motion_flag;
	assign roller_next = out_q.roller_next;
	assign intake_next = out_q.intake_next;
	assign intake_open = out_q.intake_open;
	assign status      = out_q.status;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for crc8_framed_command_receiver: serial byte frames in, decoded commands out.
// Predicts each result from its own frame parser and CRC-8; depends on crc8fcr_pkg and the RTL.
module tb;
	import crc8fcr_pkg::*;

	localparam int FRAME_MAX    = 16;
	localparam int RANDOM_WORDS = 650;
	localparam int CALM_AFTER   = 570;

	typedef struct packed {
		logic [31:0] x_bits;
		logic [31:0] y_bits;
		logic [31:0] w_bits;
		logic [7:0]  motion_flag;
		logic [7:0]  roller_next;
		logic [7:0]  intake_next;
		logic [7:0]  intake_open;
		logic [1:0]  status;
	} cmd_result_t;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_COUNT} fill_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] x_bits;
	logic [31:0] y_bits;
	logic [31:0] w_bits;
	logic [7:0]  motion_flag;
	logic [7:0]  roller_next;
	logic [7:0]  intake_next;
	logic [7:0]  intake_open;
	logic [1:0]  status;

	crc8_framed_command_receiver #(
		.MAX_PAYLOAD(FRAME_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.x_bits(x_bits),
		.y_bits(y_bits),
		.w_bits(w_bits),
		.motion_flag(motion_flag),
		.roller_next(roller_next),
		.intake_next(intake_next),
		.intake_open(intake_open),
		.status(status)
	);

	// frame parser state of the predictor
	rx_state_t   parse_stage;
	logic [7:0]  hunt_last;
	logic [5:0]  data_count;
	logic [5:0]  data_len;
	logic [7:0]  crc_acc;
	logic        tail_one;
	logic [7:0]  cmd_store [STORE_DEPTH];

	cmd_result_t expected_cmds[$];

	int  fail_count;
	int  words_sent;
	int  good_seen;
	int  crc_err_seen;
	int  len_err_seen;
	bit  calm;
	bit  gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

	function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			r = {1'b0, r[7:1]} ^ ((r[0] ^ data[k]) ? 8'h8C : 8'h00);
		end
		return r;
	endfunction

	task automatic parser_restart();
		parse_stage = ST_HUNT;
		hunt_last   = 8'h00;
		data_count  = '0;
		data_len    = '0;
		crc_acc     = 8'h00;
		tail_one    = 1'b0;
	endtask

	task automatic push_result(input logic [1:0] code);
		cmd_result_t r;
		r = '0;
		r.status = code;
		if (code == STATUS_OK) begin
			r.x_bits      = {cmd_store[3], cmd_store[2], cmd_store[1], cmd_store[0]};
			r.y_bits      = {cmd_store[7], cmd_store[6], cmd_store[5], cmd_store[4]};
			r.w_bits      = {cmd_store[11], cmd_store[10], cmd_store[9], cmd_store[8]};
			r.motion_flag = cmd_store[12];
			r.roller_next = cmd_store[13];
			r.intake_next = cmd_store[14];
			r.intake_open = cmd_store[15];
		end
		expected_cmds.push_back(r);
		parser_restart();
	endtask

	task automatic parse_byte(input logic [7:0] b);
		case (parse_stage)
			ST_HUNT: begin
				if (b == HDR_SECOND) begin
					if (hunt_last == HDR_FIRST) begin
						parse_stage = ST_LEN;
						data_count  = '0;
						tail_one    = 1'b0;
						crc_acc     = crc8_next(crc8_next(8'h00, HDR_FIRST), HDR_SECOND);
					end
				end else begin
					hunt_last = b;
				end
			end
			ST_LEN: begin
				crc_acc = crc8_next(crc_acc, b);
				if (b > FRAME_MAX) begin
					push_result(STATUS_LEN_ERR);
				end else begin
					data_len    = b[5:0];
					data_count  = '0;
					parse_stage = (b == 8'd0) ? ST_CRC : ST_DATA;
				end
			end
			ST_DATA: begin
				crc_acc = crc8_next(crc_acc, b);
				if (data_count < STORE_DEPTH) begin
					cmd_store[data_count[3:0]] = b;
				end
				data_count = data_count + 6'd1;
				if (data_count >= data_len) begin
					parse_stage = ST_CRC;
				end
			end
			ST_CRC: begin
				if (b != crc_acc) begin
					push_result(STATUS_CRC_ERR);
				end else begin
					parse_stage = ST_TAIL;
					tail_one    = 1'b0;
				end
			end
			default: begin
				if (!tail_one) begin
					tail_one = 1'b1;
				end else begin
					push_result(STATUS_OK);
				end
			end
		endcase
	endtask

	task automatic send_word(input logic [7:0] b);
		if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		parse_byte(b);
		words_sent++;
	endtask

	// hold the sender until every expected result is out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_frame(input logic [7:0] len, input fill_t fill, input bit bad_crc);
		logic [7:0] c;
		logic [7:0] d;
		gaps_on = $urandom_range(0, 1);
		c = crc8_next(crc8_next(8'h00, HDR_FIRST), HDR_SECOND);
		send_word(HDR_FIRST);
		send_word(HDR_SECOND);
		send_word(len);
		c = crc8_next(c, len);
		if (len > FRAME_MAX) begin
			return;
		end
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO:  d = 8'h00;
				FILL_ONES:  d = 8'hFF;
				FILL_COUNT: d = 8'(i * 17 + 1);
				default:    d = 8'($urandom);
			endcase
			send_word(d);
			c = crc8_next(c, d);
		end
		if (bad_crc) begin
			c = c ^ (8'h01 << $urandom_range(0, 7));
		end
		send_word(c);
		send_word(8'($urandom));
		send_word(8'($urandom));
	endtask

	task automatic send_noise(input int n);
		logic [7:0] d;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0:       d = HDR_FIRST;
				1:       d = HDR_SECOND;
				default: d = 8'($urandom);
			endcase
			send_word(d);
		end
	endtask

	task automatic test_header_hunt();
		// lone 0xAA, 0xAA after other bytes, then a run of 0x55 ending in a frame
		send_word(HDR_SECOND);
		send_word(8'h12);
		send_word(HDR_SECOND);
		send_word(HDR_SECOND);
		send_word(HDR_FIRST);
		send_frame(8'd0, FILL_ZERO, 1'b0);
	endtask

	task automatic test_full_frame();
		send_frame(8'(FRAME_MAX), FILL_ONES, 1'b0);
		send_frame(8'd2, FILL_COUNT, 1'b0);
	endtask

	task automatic test_oversize_length();
		send_frame(8'(FRAME_MAX + 1), FILL_RANDOM, 1'b0);
		send_frame(8'hFF, FILL_RANDOM, 1'b0);
		// hunt restarts with no remembered header byte
		send_word(HDR_SECOND);
	endtask

	task automatic test_crc_mismatch();
		send_frame(8'd5, FILL_ZERO, 1'b1);
		send_word(HDR_SECOND);
		send_frame(8'd0, FILL_RANDOM, 1'b0);
		drain_results();
	endtask

	task automatic test_random_traffic();
		int pick;
		int n;
		while (words_sent < RANDOM_WORDS) begin
			if (words_sent >= CALM_AFTER) begin
				calm = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				n = ($urandom_range(0, 3) == 0) ? FRAME_MAX : $urandom_range(0, FRAME_MAX);
				send_frame(8'(n), FILL_RANDOM, 1'b0);
			end else if (pick < 80) begin
				send_frame(8'($urandom_range(0, FRAME_MAX)), FILL_RANDOM, 1'b1);
			end else if (pick < 87) begin
				send_frame(8'($urandom_range(FRAME_MAX + 1, 255)), FILL_RANDOM, 1'b0);
			end else if (pick < 93) begin
				// frame cut short, following bytes get parsed as its body
				n = $urandom_range(1, FRAME_MAX);
				send_word(HDR_FIRST);
				send_word(HDR_SECOND);
				send_word(8'(n));
				send_noise($urandom_range(0, n));
			end else begin
				send_noise($urandom_range(1, 6));
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cmd_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				$error("unexpected result, status %0d", status);
				fail_count++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("x_bits", want.x_bits, x_bits);
				check_field("y_bits", want.y_bits, y_bits);
				check_field("w_bits", want.w_bits, w_bits);
				check_field("motion_flag", 32'(want.motion_flag), 32'(motion_flag));
				check_field("roller_next", 32'(want.roller_next), 32'(roller_next));
				check_field("intake_next", 32'(want.intake_next), 32'(intake_next));
				check_field("intake_open", 32'(want.intake_open), 32'(intake_open));
				check_field("status", 32'(want.status), 32'(status));
				case (status)
					STATUS_OK:      good_seen++;
					STATUS_CRC_ERR: crc_err_seen++;
					default:        len_err_seen++;
				endcase
			end
		end
	end

	initial begin
		int stall_pct;
		int left;
		left = 0;
		stall_pct = 0;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (left == 0) begin
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
				left = $urandom_range(20, 80);
			end
			left--;
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		rx_byte  = 8'h00;
		fail_count   = 0;
		words_sent   = 0;
		good_seen    = 0;
		crc_err_seen = 0;
		len_err_seen = 0;
		calm    = 1'b0;
		gaps_on = 1'b0;
		parser_restart();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			cmd_store[i] = 8'h00;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_hunt();
		test_full_frame();
		test_oversize_length();
		test_crc_mismatch();
		test_random_traffic();

		calm = 1'b1;
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d words incl. header hunting, oversize lengths and broken frames.",
			words_sent);
		$display("Checked %0d good frames, %0d crc errors, %0d length errors.",
			good_seen, crc_err_seen, len_err_seen);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

FILE: crc8_framed_command_receiver.f
rtl/crc8fcr_pkg.sv
rtl/crc8fcr_parser.sv
rtl/crc8_framed_command_receiver.sv
tb/tb.sv
